>>> rtl/mf_pkg.sv
// Package for the 2-D median filter: defaults, state codes and shared types.
`default_nettype none
package mf_pkg;

  localparam int MF_MAX_COLS   = 1024;
  localparam int MF_MAX_ROWS   = 1024;
  localparam int MF_MAX_RADIUS = 4;

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [10:0] ROWS_RST   = 11'd1024;
  localparam logic [10:0] COLS_RST   = 11'd1024;
  localparam logic [2:0]  RADIUS_RST = 3'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CHK,
    S_SCAN,
    S_DRAIN,
    S_PASS,
    S_OUT,
    S_WRITE
  } state_t;

  // controls from the sequencer to the rank unit
  typedef struct packed {
    logic       start;
    logic       dv;
    logic [7:0] dat;
    logic       pass_end;
  } rank_ctl_t;

endpackage
`default_nettype wire

>>> rtl/mf_in_if.sv
// Input channel: command and pixel with valid/ready.
`default_nettype none
interface mf_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pixel;
  modport source (output valid, command, pixel, input ready);
  modport sink (input valid, command, pixel, output ready);
endinterface
`default_nettype wire

>>> rtl/mf_out_if.sv
// Result channel: filtered pixel and end-of-frame flag with valid/ready.
`default_nettype none
interface mf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_pixel;
  logic       last_of_frame;
  modport source (output valid, filtered_pixel, last_of_frame, input ready);
  modport sink (input valid, filtered_pixel, last_of_frame, output ready);
endinterface
`default_nettype wire

>>> rtl/image_median_filter_top.sv
// An item without a result passes the evaluate and check states; one with a result also makes
// one pass over the window per result bit, i.e. over up to 81 values for a 9x9 window.
// The rate is set by the single read port of the line store: one window value per cycle,
// re-read once for each of the 8 result bits. One item is worked on at a time.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, synchronous) clears counters and loads register defaults; no clearing pass.
`default_nettype none
module image_median_filter_top
  import mf_pkg::*;
#(
  parameter int MAX_COLS   = MF_MAX_COLS,
  parameter int MAX_ROWS   = MF_MAX_ROWS,
  parameter int MAX_RADIUS = MF_MAX_RADIUS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mf_in_if.sink                  in_s,
  mf_out_if.source               out_s,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  localparam int L     = 2 * MAX_RADIUS + 1;
  localparam int LW    = $clog2(L);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RADW  = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH = L * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  state_t state_r, state_nxt;

  logic [10:0] rows_r, cols_r;
  logic [2:0]  rad_r;
  logic [RW-1:0]   rows_c;
  logic [CW-1:0]   cols_c;
  logic [RADW-1:0] rad_c;

  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [LW-1:0] in_ring_r, in_ring_nxt, out_ring_r, out_ring_nxt;
  logic          done_r, done_nxt;

  logic          cmd_r, acc_r, acc_nxt, last_r, last_nxt;
  logic [7:0]    pix_r;
  logic [RW-1:0] pr_r, pr_nxt, x0_r, x0_nxt, nr_r, nr_nxt, sx_r, sx_nxt;
  logic [CW-1:0] pc_r, pc_nxt, y0_r, y0_nxt, nc_r, nc_nxt, sy_r, sy_nxt;
  logic [LW-1:0] pring_r, pring_nxt, x0ring_r, x0ring_nxt, sring_r, sring_nxt;
  logic          dv_r, fwd_r, fwd_nxt;

  logic [RW:0]   nr_w;
  logic [CW:0]   nc_w;
  logic [RW-1:0] nr_c;
  logic [CW-1:0] nc_c;
  logic          ready_w;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  rank_ctl_t     rctl;
  logic          last_pass;
  logic [7:0]    median;

  logic          ov_r, ov_nxt;
  logic [7:0]    opix_r, opix_nxt;
  logic          olast_r, olast_nxt;

  logic cfg_wr, cfg_hit;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = cfg_wr && (cfg_paddr[3:2] == REG_ROWS || cfg_paddr[3:2] == REG_COLS ||
                                 cfg_paddr[3:2] == REG_RADIUS);

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ROWS:   cfg_prdata = {21'd0, rows_r};
      REG_COLS:   cfg_prdata = {21'd0, cols_r};
      REG_RADIUS: cfg_prdata = {29'd0, rad_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
      rad_r  <= RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_ROWS:   rows_r <= cfg_pwdata[10:0];
        REG_COLS:   cols_r <= cfg_pwdata[10:0];
        REG_RADIUS: rad_r  <= cfg_pwdata[2:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (rows_r == 11'd0) begin
      rows_c = RW'(1);
    end else if ({1'b0, rows_r} > 12'(MAX_ROWS)) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(rows_r);
    end
    if (cols_r == 11'd0) begin
      cols_c = CW'(1);
    end else if ({1'b0, cols_r} > 12'(MAX_COLS)) begin
      cols_c = CW'(MAX_COLS);
    end else begin
      cols_c = CW'(cols_r);
    end
    if ({1'b0, rad_r} > 4'(MAX_RADIUS)) begin
      rad_c = RADW'(MAX_RADIUS);
    end else begin
      rad_c = RADW'(rad_r);
    end
  end

  // ---------------- window bounds ----------------
  assign nr_w = {1'b0, out_row_r} + (RW+1)'(rad_c);
  assign nc_w = {1'b0, out_col_r} + (CW+1)'(rad_c);
  assign nr_c = (nr_w > (RW+1)'(rows_c - RW'(1))) ? rows_c - RW'(1) : nr_w[RW-1:0];
  assign nc_c = (nc_w > (CW+1)'(cols_c - CW'(1))) ? cols_c - CW'(1) : nc_w[CW-1:0];
  assign ready_w = done_r || (nr_c < in_row_r) || (nr_c == in_row_r && nc_c < in_col_r);

  // ---------------- sequencer ----------------
  assign in_s.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_ring_nxt  = in_ring_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_ring_nxt = out_ring_r;
    done_nxt     = done_r;
    acc_nxt      = acc_r;
    pr_nxt       = pr_r;
    pc_nxt       = pc_r;
    pring_nxt    = pring_r;
    x0_nxt       = x0_r;
    y0_nxt       = y0_r;
    nr_nxt       = nr_r;
    nc_nxt       = nc_r;
    x0ring_nxt   = x0ring_r;
    last_nxt     = last_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    sring_nxt    = sring_r;
    fwd_nxt      = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    rctl.start   = 1'b0;
    rctl.pass_end = 1'b0;
    rctl.dv      = dv_r;
    rctl.dat     = fwd_r ? pix_r : ram_rdata;
    ov_nxt       = ov_r && !out_s.ready;
    opix_nxt     = opix_r;
    olast_nxt    = olast_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        acc_nxt   = !cmd_r && !done_r;
        pr_nxt    = in_row_r;
        pc_nxt    = in_col_r;
        pring_nxt = in_ring_r;
        if (!cmd_r && !done_r) begin
          if (in_col_r + CW'(1) >= cols_c) begin
            in_col_nxt  = '0;
            in_row_nxt  = in_row_r + RW'(1);
            in_ring_nxt = (in_ring_r == LW'(L - 1)) ? '0 : in_ring_r + LW'(1);
            if (in_row_r + RW'(1) >= rows_c) begin
              done_nxt = 1'b1;
            end
          end else begin
            in_col_nxt = in_col_r + CW'(1);
          end
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (ready_w) begin
          nr_nxt   = nr_c;
          nc_nxt   = nc_c;
          last_nxt = (out_row_r >= rows_c - RW'(1)) && (out_col_r >= cols_c - CW'(1));
          if (out_row_r >= RW'(rad_c)) begin
            x0_nxt     = out_row_r - RW'(rad_c);
            x0ring_nxt = (out_ring_r >= LW'(rad_c)) ? out_ring_r - LW'(rad_c)
                                                    : out_ring_r + LW'(L) - LW'(rad_c);
          end else begin
            x0_nxt     = '0;
            x0ring_nxt = '0;
          end
          y0_nxt     = (out_col_r >= CW'(rad_c)) ? out_col_r - CW'(rad_c) : '0;
          sx_nxt     = x0_nxt;
          sy_nxt     = y0_nxt;
          sring_nxt  = x0ring_nxt;
          rctl.start = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = acc_r ? S_WRITE : S_IDLE;
        end
      end
      S_SCAN: begin
        ram_re  = 1'b1;
        fwd_nxt = acc_r && (sx_r == pr_r) && (sy_r == pc_r);
        if (sy_r == nc_r) begin
          sy_nxt = y0_r;
          if (sx_r == nr_r) begin
            state_nxt = S_DRAIN;
          end else begin
            sx_nxt    = sx_r + RW'(1);
            sring_nxt = (sring_r == LW'(L - 1)) ? '0 : sring_r + LW'(1);
          end
        end else begin
          sy_nxt = sy_r + CW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_PASS;
      end
      S_PASS: begin
        rctl.pass_end = 1'b1;
        sx_nxt        = x0_r;
        sy_nxt        = y0_r;
        sring_nxt     = x0ring_r;
        state_nxt     = last_pass ? S_OUT : S_SCAN;
      end
      S_OUT: begin
        if (!ov_r || out_s.ready) begin
          ov_nxt    = 1'b1;
          opix_nxt  = median;
          olast_nxt = last_r;
          if (last_r) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            in_ring_nxt  = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            out_ring_nxt = '0;
            done_nxt     = 1'b0;
          end else if (out_col_r + CW'(1) >= cols_c) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + RW'(1);
            out_ring_nxt = (out_ring_r == LW'(L - 1)) ? '0 : out_ring_r + LW'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
          state_nxt = acc_r ? S_WRITE : S_IDLE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // a register write restarts the frame
    if (cfg_hit) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_ring_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_ring_nxt = '0;
      done_nxt     = 1'b0;
    end
  end

  assign ram_raddr = AW'(sring_r) * AW'(MAX_COLS) + AW'(sy_r);
  assign ram_waddr = AW'(pring_r) * AW'(MAX_COLS) + AW'(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
      done_r     <= 1'b0;
      acc_r      <= 1'b0;
      dv_r       <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_ring_r  <= in_ring_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_ring_r <= out_ring_nxt;
      done_r     <= done_nxt;
      acc_r      <= acc_nxt;
      dv_r       <= ram_re;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      cmd_r <= in_s.command;
      pix_r <= in_s.pixel;
    end
    pr_r     <= pr_nxt;
    pc_r     <= pc_nxt;
    pring_r  <= pring_nxt;
    x0_r     <= x0_nxt;
    y0_r     <= y0_nxt;
    nr_r     <= nr_nxt;
    nc_r     <= nc_nxt;
    x0ring_r <= x0ring_nxt;
    last_r   <= last_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    sring_r  <= sring_nxt;
    fwd_r    <= fwd_nxt;
    opix_r   <= opix_nxt;
    olast_r  <= olast_nxt;
  end

  mf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pix_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mf_rank #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rctl),
    .last_pass(last_pass),
    .median   (median)
  );

  assign out_s.valid          = ov_r;
  assign out_s.filtered_pixel = opix_r;
  assign out_s.last_of_frame  = olast_r;

  // ---------------- assertions ----------------
  a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r < rows_c) else $error("output row beyond frame");

  a_in_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < cols_c) else $error("input column beyond frame");

  a_write_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> acc_r) else $error("store write without an accepted pixel");

  a_result_after_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> $past(state_r) == S_OUT || $past(last_pass))
    else $error("result loaded before all passes");

endmodule
`default_nettype wire

>>> rtl/mf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mf_rank.sv
// Bit-serial rank selector: one result bit per pass over the window, MSB first.
`default_nettype none
module mf_rank
  import mf_pkg::*;
#(
  parameter int MAX_RADIUS = MF_MAX_RADIUS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rank_ctl_t  ctl,
  output logic            last_pass,
  output logic [7:0]      median
);

  localparam int WIN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int KW  = $clog2(WIN + 1);

  logic [2:0]    bit_r, bit_nxt;
  logic [7:0]    prefix_r, prefix_nxt;
  logic [KW-1:0] k_r, k_nxt, cnt_r, cnt_nxt, tot_r, tot_nxt, k_eff;
  logic          first_r, first_nxt;
  logic [7:0]    hi_mask;
  logic          match;

  assign hi_mask = 8'(9'h0FF << ({1'b0, bit_r} + 4'd1));
  assign match   = (((ctl.dat ^ prefix_r) & hi_mask) == 8'd0) && !ctl.dat[bit_r];
  assign k_eff   = first_r ? (tot_r >> 1) : k_r;

  always_comb begin
    bit_nxt    = bit_r;
    prefix_nxt = prefix_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    tot_nxt    = tot_r;
    first_nxt  = first_r;
    if (ctl.start) begin
      bit_nxt    = 3'd7;
      prefix_nxt = 8'd0;
      cnt_nxt    = '0;
      tot_nxt    = '0;
      first_nxt  = 1'b1;
    end else if (ctl.dv) begin
      if (first_r) begin
        tot_nxt = tot_r + KW'(1);
      end
      if (match) begin
        cnt_nxt = cnt_r + KW'(1);
      end
    end else if (ctl.pass_end) begin
      // fewer than k+1 values below with a zero here: this bit is one
      if (k_eff >= cnt_r) begin
        prefix_nxt[bit_r] = 1'b1;
        k_nxt             = k_eff - cnt_r;
      end else begin
        k_nxt = k_eff;
      end
      cnt_nxt   = '0;
      first_nxt = 1'b0;
      bit_nxt   = bit_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r   <= 3'd7;
      first_r <= 1'b1;
      cnt_r   <= '0;
      tot_r   <= '0;
    end else begin
      bit_r   <= bit_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
      tot_r   <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prefix_r <= prefix_nxt;
    k_r      <= k_nxt;
  end

  assign last_pass = (bit_r == 3'd0);
  assign median    = prefix_r;

endmodule
`default_nettype wire

>>> sim/tb_image_median_filter_top.sv
// Testbench for the streaming 2-D median filter: directed and random frames checked against a scoreboard.
`timescale 1ns / 1ps
module tb_image_median_filter_top
  import mf_pkg::*;
();

  localparam int STORE_LINES = 2 * MF_MAX_RADIUS + 1;

  typedef struct {
    logic [7:0] filtered_pixel;
    logic       last_of_frame;
  } median_result_t;

  class median_scoreboard;
    logic [7:0]     line_store [STORE_LINES * MF_MAX_COLS];
    logic [10:0]    rows_reg, cols_reg;
    logic [2:0]     radius_reg;
    int             in_row, in_col, out_row, out_col;
    bit             in_done;
    int             frames_done;
    int             mismatches;
    median_result_t expected_pixels[$];

    function new();
      rows_reg = ROWS_RST;
      cols_reg = COLS_RST;
      radius_reg = RADIUS_RST;
      restart();
      frames_done = 0;
      mismatches = 0;
    endfunction

    function void restart();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      in_done = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_ROWS: begin
          rows_reg = val[10:0];
        end
        REG_COLS: begin
          cols_reg = val[10:0];
        end
        REG_RADIUS: begin
          radius_reg = val[2:0];
        end
        default: return;
      endcase
      restart();
    endfunction

    // works out the output (if any) caused by one accepted input transfer
    function void note_pixel_item(logic cmd, logic [7:0] pix);
      int rows, cols, rad, pr, pc, nr, nc, x0, y0, total, acc, cnt;
      int hist [256];
      bit take, ready, last;
      logic [7:0] med, val;
      median_result_t res;
      rows = (rows_reg < 1) ? 1 : (rows_reg > MF_MAX_ROWS) ? MF_MAX_ROWS : int'(rows_reg);
      cols = (cols_reg < 1) ? 1 : (cols_reg > MF_MAX_COLS) ? MF_MAX_COLS : int'(cols_reg);
      rad = (radius_reg > MF_MAX_RADIUS) ? MF_MAX_RADIUS : int'(radius_reg);
      take = (cmd == 1'b0) && !in_done;
      pr = in_row; pc = in_col;
      if (take) begin
        in_col++;
        if (in_col >= cols) begin
          in_col = 0;
          in_row++;
          if (in_row >= rows) in_done = 1;
        end
      end
      nr = (out_row + rad > rows - 1) ? rows - 1 : out_row + rad;
      nc = (out_col + rad > cols - 1) ? cols - 1 : out_col + rad;
      ready = in_done || nr < in_row || (nr == in_row && nc < in_col);
      if (ready) begin
        foreach (hist[i]) hist[i] = 0;
        x0 = (out_row >= rad) ? out_row - rad : 0;
        y0 = (out_col >= rad) ? out_col - rad : 0;
        total = 0;
        for (int x = x0; x <= nr; x++) begin
          for (int y = y0; y <= nc; y++) begin
            // incoming pixel is forwarded, store not yet written
            if (take && x == pr && y == pc) val = pix;
            else val = line_store[(x % STORE_LINES) * MF_MAX_COLS + y];
            hist[val]++;
            total++;
          end
        end
        acc = 0;
        med = 0;
        for (int v = 0; v < 256; v++) begin
          acc += hist[v];
          if (acc > total / 2) begin
            med = v[7:0];
            break;
          end
        end
        last = (out_row >= rows - 1) && (out_col >= cols - 1);
        res.filtered_pixel = med;
        res.last_of_frame = last;
        expected_pixels.push_back(res);
        if (take) line_store[(pr % STORE_LINES) * MF_MAX_COLS + pc] = pix;
        take = 0;
        if (last) begin
          restart();
          frames_done++;
        end else begin
          out_col++;
          if (out_col >= cols) begin
            out_col = 0;
            out_row++;
          end
        end
      end
      if (take) line_store[(pr % STORE_LINES) * MF_MAX_COLS + pc] = pix;
    endfunction

    function void check_pixel(logic [7:0] fp, logic last);
      median_result_t exp_res;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output pixel %0d last %0b", $realtime, fp, last);
        return;
      end
      exp_res = expected_pixels.pop_front();
      if (fp !== exp_res.filtered_pixel || last !== exp_res.last_of_frame) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   $realtime, exp_res.filtered_pixel, exp_res.last_of_frame, fp, last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  bit          quiet;
  int          item_count;

  mf_in_if  in_ch();
  mf_out_if out_ch();

  median_scoreboard sb;

  image_median_filter_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch), .out_s(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_pixel(out_ch.filtered_pixel, out_ch.last_of_frame);
  end

  // result side stalls in bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_item(logic cmd, logic [7:0] pix);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pixel <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_pixel_item(cmd, pix);
    item_count++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_frame(int rows, int cols, int rad);
    wait_idle();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_RADIUS, rad);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // feeds items until the frame's final output has been predicted
  task automatic run_frame(int drain_pct);
    int start;
    start = sb.frames_done;
    while (sb.frames_done == start) begin
      if (sb.in_done) send_item($urandom_range(0, 3) != 0, pick_pixel());
      else send_item($urandom_range(0, 99) < drain_pct, pick_pixel());
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    quiet = 0;
    item_count = 0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.pixel = 8'd0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clamped sizes, both radius extremes, abandoned frame, bad register
    set_frame(0, 0, 7);
    run_frame(0);
    set_frame(2, 3, 4);
    run_frame(10);
    set_frame(3, 2, 1);
    run_frame(10);
    set_frame(4, 6, 2);
    repeat (10) send_item(1'b0, pick_pixel());
    wait_idle();
    write_reg(2'd3, 32'h5);
    set_frame(2, 2, 0);
    run_frame(20);

    while (item_count < 50) begin
      set_frame($urandom_range(1, 6), $urandom_range(1, 12), $urandom_range(0, 4));
      run_frame(15);
    end

    // widest row (clamped), no idling from here on
    quiet = 1;
    set_frame(1, 2047, $urandom_range(0, 4));
    run_frame(2);

    in_ch.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_image_median_filter_top: PASS");
    end else begin
      $display("tb_image_median_filter_top: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_image_median_filter_top: FAIL");
    $finish;
  end

endmodule
